/* rtl/msf_pkg.sv */
// ----------------------------------------------------------------------------
// msf_pkg
// Types and constants shared by the sustain/sostenuto pedal filter.
// ----------------------------------------------------------------------------
package msf_pkg;

	localparam int NUM_CHANNELS_DEF = 16;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 192;
	localparam int CFG_IDX_W   = 2;

	localparam logic [3:0] MT_NOTE_OFF = 4'h8;
	localparam logic [3:0] MT_NOTE_ON  = 4'h9;
	localparam logic [3:0] MT_CC       = 4'hB;

	localparam logic [7:0] CC_SUSTAIN   = 8'd64;
	localparam logic [7:0] CC_SOSTENUTO = 8'd66;
	localparam logic [6:0] CC_SOUND_OFF = 7'd120;
	localparam logic [6:0] CC_NOTES_OFF = 7'd123;
	localparam logic [6:0] PEDAL_THRESH = 7'd63;
	localparam logic [7:0] ST_SYS_RESET = 8'hFF;

	localparam logic [1:0] SIZE_ONE   = 2'd1;
	localparam logic [1:0] SIZE_TWO   = 2'd2;
	localparam logic [1:0] SIZE_THREE = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STYLE = 2'd0,
		REG_CTRL  = 2'd1,
		REG_FWD   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic style;
		logic ctrl;
		logic fwd_pedal;
	} cfg_t;

	typedef struct packed {
		logic         pedal;
		logic [127:0] keys;
	} row_t;

	typedef struct packed {
		logic [31:0] event_time;
		logic [1:0]  msg_size;
		logic [7:0]  status_byte;
		logic [7:0]  data_one;
		logic [7:0]  data_two;
	} item_t;

	typedef struct packed {
		logic [31:0] out_time;
		logic [3:0]  release_channel;
		logic [63:0] release_low;
		logic [63:0] release_high;
		logic        fwd_valid;
		logic [1:0]  fwd_size;
		logic [7:0]  fwd_status;
		logic [7:0]  fwd_data_one;
		logic [7:0]  fwd_data_two;
	} result_t;

endpackage

/* rtl/midi_sustain_pedal_filter.sv */
// Path: an accepted request is registered together with its row read; its result
// is then registered at the output, delayed only while a receiver stalls.
// Throughput: one request per cycle unless the receiver stalls, same channel
// included; the single row memory is read at accept and written on advance, with a bypass.
// Reset: config registers, pedal flags and held keys clear at once (per-row
// valid bits make unwritten rows read as zero); no clearing pass.
// ----------------------------------------------------------------------------
// midi_sustain_pedal_filter
// Sustain/sostenuto pedal filter: tracks pedal and held keys per channel and
// emits release masks plus the optionally forwarded message.
// ----------------------------------------------------------------------------
module midi_sustain_pedal_filter
	import msf_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic                   cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// event_time, msg_size, status_byte, data_one, data_two, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_time, release_channel, release_low, release_high, fwd_size,
	// fwd_status, fwd_data_one, fwd_data_two, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// fwd_valid
	output logic                   m_axis_tuser
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	cfg_t    cfg_q;
	item_t   in_item;
	item_t   item_s1;
	logic    vld_s1;
	logic    adv_s1;
	logic    accept;
	row_t    rd_row;
	row_t    new_row;
	logic    upd_en;
	logic    wr_en;
	result_t res;
	result_t out_q;
	logic    out_vld_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STYLE: cfg_q.style     <= cfg_data;
				REG_CTRL:  cfg_q.ctrl      <= cfg_data;
				REG_FWD:   cfg_q.fwd_pedal <= cfg_data;
				default:   ;
			endcase
		end
	end

	assign in_item.event_time  = s_axis_tdata[31:0];
	assign in_item.msg_size    = s_axis_tdata[33:32];
	assign in_item.status_byte = s_axis_tdata[41:34];
	assign in_item.data_one    = s_axis_tdata[49:42];
	assign in_item.data_two    = s_axis_tdata[57:50];

	assign adv_s1        = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign wr_en         = adv_s1 && upd_en;

	msf_row_mem #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.CH_W         (CH_W)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_item.status_byte[CH_W-1:0]),
		.wr_en   (wr_en),
		.wr_addr (item_s1.status_byte[CH_W-1:0]),
		.wr_row  (new_row),
		.rd_row  (rd_row)
	);

	msf_event_logic #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_event_logic (
		.item    (item_s1),
		.row     (rd_row),
		.cfg     (cfg_q),
		.wr_en   (upd_en),
		.new_row (new_row),
		.res     (res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		if (adv_s1) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.fwd_valid;
	assign m_axis_tdata  = {2'b00, out_q.fwd_data_two, out_q.fwd_data_one, out_q.fwd_status,
		out_q.fwd_size, out_q.release_high, out_q.release_low, out_q.release_channel,
		out_q.out_time};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && out_vld_q && !m_axis_tready))
		else $error("input stalled without a blocked result");

	a_write_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (vld_s1 && adv_s1))
		else $error("row write without an advancing request");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_q.fwd_valid) |->
		(out_q.fwd_size == 2'd0 && out_q.fwd_status == 8'd0))
		else $error("dropped message carries payload");

	a_range_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && ({1'b0, out_q.release_channel} >= 5'(NUM_CHANNELS))) |->
		(out_q.release_low == '0 && out_q.release_high == '0 && out_q.fwd_valid))
		else $error("out-of-range channel touched state");

endmodule

/* rtl/msf_row_mem.sv */
// ----------------------------------------------------------------------------
// msf_row_mem
// Per-channel state memory: pedal flag and 128 held-key bits per row.
// Registered read, write-to-read bypass, per-row valid bits cleared at reset.
// ----------------------------------------------------------------------------
module msf_row_mem
	import msf_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int CH_W         = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [CH_W-1:0] rd_addr,
	input  logic            wr_en,
	input  logic [CH_W-1:0] wr_addr,
	input  row_t            wr_row,
	output row_t            rd_row
);

	row_t                    mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;
	row_t                    rd_q;
	row_t                    byp_q;
	logic                    byp_sel_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			byp_q <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			byp_sel_q <= 1'b0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				byp_sel_q <= wr_en && (wr_addr == rd_addr);
				rd_vld_q  <= vld_q[rd_addr];
			end
		end
	end

	always_comb begin
		if (byp_sel_q) begin
			rd_row = byp_q;
		end else if (rd_vld_q) begin
			rd_row = rd_q;
		end else begin
			rd_row = '0;
		end
	end

endmodule

/* rtl/msf_event_logic.sv */
// ----------------------------------------------------------------------------
// msf_event_logic
// Decodes one MIDI message against its channel row and builds the new row
// and the result item.
// ----------------------------------------------------------------------------
module msf_event_logic
	import msf_pkg::*;
#(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  item_t   item,
	input  row_t    row,
	input  cfg_t    cfg,
	output logic    wr_en,
	output row_t    new_row,
	output result_t res
);

	logic [3:0] mtype;
	logic [6:0] key;
	logic [6:0] vel;
	logic       in_range;
	logic       is_cc;
	logic       is_pedal;
	logic       panic;
	logic       pedal_n;
	logic       release_all;
	logic       is_note;
	logic       is_off;
	logic       swallow;
	logic       collect;
	logic       fwd;

	always_comb begin
		mtype    = item.status_byte[7:4];
		key      = item.data_one[6:0];
		vel      = item.data_two[6:0];
		in_range = {1'b0, item.status_byte[3:0]} < 5'(NUM_CHANNELS);

		is_cc    = (item.msg_size == SIZE_THREE) && (mtype == MT_CC);
		is_pedal = is_cc && (item.data_one == (cfg.ctrl ? CC_SOSTENUTO : CC_SUSTAIN));
		panic    = (is_cc && ((key == CC_SOUND_OFF) || (key == CC_NOTES_OFF)))
			|| ((item.msg_size == SIZE_ONE) && (item.status_byte == ST_SYS_RESET));

		pedal_n     = is_pedal ? (vel > PEDAL_THRESH) : row.pedal;
		release_all = panic || (row.pedal && !pedal_n);

		is_note = !panic && (item.msg_size == SIZE_THREE)
			&& ((mtype == MT_NOTE_ON) || (mtype == MT_NOTE_OFF));
		is_off  = (mtype == MT_NOTE_OFF) || (vel == 7'd0);
		swallow = is_note && pedal_n && is_off && row.keys[key];
		collect = is_note && !swallow && !(pedal_n && cfg.style);

		new_row.pedal = pedal_n;
		new_row.keys  = release_all ? '0 : row.keys;
		if (collect) begin
			new_row.keys[key] = !is_off;
		end

		fwd   = !in_range || panic || !(swallow || (is_pedal && !cfg.fwd_pedal));
		wr_en = in_range;

		res.out_time        = item.event_time;
		res.release_channel = item.status_byte[3:0];
		res.release_low     = (in_range && release_all) ? row.keys[63:0] : '0;
		res.release_high    = (in_range && release_all) ? row.keys[127:64] : '0;
		res.fwd_valid       = fwd;
		res.fwd_size        = fwd ? item.msg_size : 2'd0;
		res.fwd_status      = fwd ? item.status_byte : 8'd0;
		res.fwd_data_one    = (fwd && (item.msg_size >= SIZE_TWO)) ? item.data_one : 8'd0;
		res.fwd_data_two    = (fwd && (item.msg_size == SIZE_THREE)) ? item.data_two : 8'd0;
	end

endmodule
